// ===== design/assert_macros.svh =====
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked check, switched off while reset is asserted
`define BPE_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Clocked check that also holds across reset
`define BPE_ASSERT_RST(name, prop, msg) \
  name: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== design/bpe_pkg.sv =====
package bpe_pkg;

  // Number of control points used, 2 to 4 (cubic when 4)
  localparam int POINT_COUNT = 4;
  localparam int LEVELS      = POINT_COUNT - 1;

  localparam int COORD_W   = 10;
  localparam int FRAC_W    = 16;
  localparam int VAL_W     = COORD_W + FRAC_W;
  localparam int PARAM_W   = 17;
  localparam int OUT_FRAC  = 8;
  localparam int OUT_W     = VAL_W - (FRAC_W - OUT_FRAC);
  localparam int PROD_W    = VAL_W + PARAM_W;

  localparam logic [PARAM_W-1:0] T_ONE   = PARAM_W'(65536);
  localparam logic [OUT_W-1:0]   OUT_MAX = OUT_W'(261888);

  // Configuration space
  localparam int NUM_REGS   = 8;
  localparam int REG_IDX_W  = 3;
  localparam int ADDR_W     = REG_IDX_W + 2;
  localparam int DATA_W     = 32;
  // Register layout: x of point i at REG_X_BASE + REG_STRIDE*i, y one above it
  localparam int REG_X_BASE   = 0;
  localparam int REG_Y_OFFSET = 1;
  localparam int REG_STRIDE   = 2;

  typedef logic [COORD_W-1:0] coord_t;
  typedef logic [VAL_W-1:0]   val_t;
  typedef logic [PARAM_W-1:0] param_t;

  typedef struct packed {
    val_t x;
    val_t y;
  } point_t;

  localparam coord_t REG_RESET [NUM_REGS] = '{
    COORD_W'(100), COORD_W'(300), COORD_W'(300), COORD_W'(100),
    COORD_W'(500), COORD_W'(500), COORD_W'(700), COORD_W'(300)
  };

endpackage

// ===== design/bpe_in_if.sv =====
interface bpe_in_if;
  import bpe_pkg::*;

  logic   valid;
  logic   ready;
  param_t curve_param;

  modport source (output valid, output curve_param, input ready);
  modport sink   (input valid, input curve_param, output ready);
endinterface

// ===== design/bpe_out_if.sv =====
interface bpe_out_if;
  import bpe_pkg::*;

  logic             valid;
  logic             ready;
  logic [OUT_W-1:0] point_x;
  logic [OUT_W-1:0] point_y;

  modport source (output valid, output point_x, output point_y, input ready);
  modport sink   (input valid, input point_x, input point_y, output ready);
endinterface

// ===== design/bpe_lerp_cell.sv =====
module bpe_lerp_cell (
  input  logic             clk,
  input  logic             en,
  input  bpe_pkg::param_t  t,
  input  bpe_pkg::point_t  a,
  input  bpe_pkg::point_t  b,
  output bpe_pkg::point_t  q
);
  import bpe_pkg::*;

  param_t omt;
  point_t q_next;

  // (a*(1-t) + b*t) >> 16, truncated; never exceeds max(a, b)
  function automatic val_t lerp(val_t va, val_t vb, param_t tt, param_t om);
    logic [PROD_W-1:0] pa;
    logic [PROD_W-1:0] pb;
    logic [PROD_W-1:0] sum;
    pa  = PROD_W'(va) * PROD_W'(om);
    pb  = PROD_W'(vb) * PROD_W'(tt);
    sum = pa + pb;
    return sum[FRAC_W +: VAL_W];
  endfunction

  assign omt      = T_ONE - t;
  assign q_next.x = lerp(a.x, b.x, t, omt);
  assign q_next.y = lerp(a.y, b.y, t, omt);

  always_ff @(posedge clk) begin
    if (en) begin
      q <= q_next;
    end
  end
endmodule

// ===== design/bezier_point_eval_unit.sv =====
// Channel | Dir | Payload                  | Transfer when
// param   | in  | curve_param (17b, t*2^16) | param.valid && param.ready
// point   | out | point_x, point_y (18b)    | point.valid && point.ready
// apb     | in  | p0_x .. p3_y (10b each)   | psel && penable && pwrite
//
// One row of lerp cells per level, each row registered.
// One item per cycle sustained while point.ready holds; the last row is the output register.
// A stalled stage holds while empty stages upstream of it keep filling.
// rst is synchronous: clears stage valid bits and loads the default control points.
`include "assert_macros.svh"

module bezier_point_eval_unit (
  input  logic                        clk,
  input  logic                        rst,
  bpe_in_if.sink                      param,
  bpe_out_if.source                   point,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [bpe_pkg::ADDR_W-1:0]  paddr,
  input  logic [bpe_pkg::DATA_W-1:0]  pwdata,
  output logic [bpe_pkg::DATA_W-1:0]  prdata,
  output logic                        pready
);
  import bpe_pkg::*;

  coord_t                cfg_regs [NUM_REGS];
  logic [REG_IDX_W-1:0]  cfg_idx;

  logic [LEVELS:1]       valid;
  logic [LEVELS:1]       en;
  param_t                t_lvl [0:LEVELS-1];
  point_t                lvl   [0:LEVELS][0:POINT_COUNT-1];

  // Configuration registers
  assign cfg_idx = paddr[ADDR_W-1:2];
  assign pready  = 1'b1;
  assign prdata  = DATA_W'(cfg_regs[cfg_idx]);

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_REGS; i++) begin
        cfg_regs[i] <= REG_RESET[i];
      end
    end else if (psel && penable && pwrite && pready) begin
      cfg_regs[cfg_idx] <= pwdata[COORD_W-1:0];
    end
  end

  // Saturate t at one
  assign t_lvl[0] = (param.curve_param > T_ONE) ? T_ONE : param.curve_param;

  // Control points enter with 16 fraction bits
  for (genvar i = 0; i < POINT_COUNT; i++) begin : g_pts
    assign lvl[0][i].x = {cfg_regs[REG_X_BASE + REG_STRIDE*i], FRAC_W'(0)};
    assign lvl[0][i].y = {cfg_regs[REG_X_BASE + REG_STRIDE*i + REG_Y_OFFSET], FRAC_W'(0)};
  end

  // Stage advance: a stage moves when empty or when the one after it moves
  assign en[LEVELS] = !valid[LEVELS] || point.ready;
  for (genvar s = 1; s < LEVELS; s++) begin : g_en
    assign en[s] = !valid[s] || en[s+1];
  end
  assign param.ready = en[1];

  for (genvar s = 1; s <= LEVELS; s++) begin : g_lvl
    if (s == 1) begin : g_first
      always_ff @(posedge clk) begin
        if (rst) begin
          valid[s] <= 1'b0;
        end else if (en[s]) begin
          valid[s] <= param.valid;
        end
      end
    end else begin : g_rest
      always_ff @(posedge clk) begin
        if (rst) begin
          valid[s] <= 1'b0;
        end else if (en[s]) begin
          valid[s] <= valid[s-1];
        end
      end
    end

    // Carry t alongside the data for the next row
    if (s < LEVELS) begin : g_t
      always_ff @(posedge clk) begin
        if (en[s]) begin
          t_lvl[s] <= t_lvl[s-1];
        end
      end
    end

    for (genvar i = 0; i < POINT_COUNT; i++) begin : g_row
      if (i < POINT_COUNT - s) begin : g_used
        bpe_lerp_cell u_lerp (
          .clk (clk),
          .en  (en[s]),
          .t   (t_lvl[s-1]),
          .a   (lvl[s-1][i]),
          .b   (lvl[s-1][i+1]),
          .q   (lvl[s][i])
        );
      end else begin : g_unused
        assign lvl[s][i] = '0;
      end
    end
  end

  // Drop the extra fraction bits
  assign point.valid   = valid[LEVELS];
  assign point.point_x = lvl[LEVELS][0].x[VAL_W-1:FRAC_W-OUT_FRAC];
  assign point.point_y = lvl[LEVELS][0].y[VAL_W-1:FRAC_W-OUT_FRAC];

  `BPE_ASSERT(a_empty_out_ready, !valid[LEVELS] |-> param.ready, "input stalled with empty output")
  `BPE_ASSERT(a_accept_fills, param.valid && param.ready |=> valid[1], "accepted transfer lost")
  `BPE_ASSERT(a_point_range, point.valid |-> point.point_x <= OUT_MAX && point.point_y <= OUT_MAX, "point out of range")
  `BPE_ASSERT_RST(a_reset_clears, rst |=> !point.valid, "output valid after reset")

endmodule
